// ----- hdl/imufd_pkg.sv -----
// ----------------------------------------------------------------------------
// imufd_pkg: shared constants for the imu frame deframer
// Field widths, sync and trailer bytes and byte positions inside a frame.
// ----------------------------------------------------------------------------
package imufd_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int ID_W    = 16;
   localparam int WORD_W  = 32;
   localparam int TEMP_W  = 16;
   localparam int COUNT_W = 32;
   localparam int POS_W   = 6;

   // frame framing bytes
   localparam logic [BYTE_W-1:0] SYNC0_BYTE   = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC1_BYTE   = 8'hA4;
   localparam logic [BYTE_W-1:0] SYNC2_BYTE   = 8'h1C;
   localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h00;

   // byte positions inside a frame
   localparam logic [POS_W-1:0] POS_SYNC0    = 6'd0;
   localparam logic [POS_W-1:0] POS_SYNC1    = 6'd1;
   localparam logic [POS_W-1:0] POS_SYNC2    = 6'd2;
   localparam logic [POS_W-1:0] POS_SUM_LAST = 6'd30;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 6'd31;
   localparam logic [POS_W-1:0] POS_TRAILER  = 6'd32;

   // bytes 3 to 31 are held in a shift line, byte 3 ends up lowest
   localparam int FIRST_HELD = 3;
   localparam int HELD_BYTES = 29;
   localparam int HELD_W     = HELD_BYTES * BYTE_W;

   // bit offsets of the fields in the shift line
   localparam int OFS_ID       = (3 - FIRST_HELD) * BYTE_W;
   localparam int OFS_GYRO_X   = (5 - FIRST_HELD) * BYTE_W;
   localparam int OFS_GYRO_Y   = (9 - FIRST_HELD) * BYTE_W;
   localparam int OFS_GYRO_Z   = (13 - FIRST_HELD) * BYTE_W;
   localparam int OFS_ACCEL_X  = (17 - FIRST_HELD) * BYTE_W;
   localparam int OFS_ACCEL_Y  = (21 - FIRST_HELD) * BYTE_W;
   localparam int OFS_ACCEL_Z  = (25 - FIRST_HELD) * BYTE_W;
   localparam int OFS_TEMP     = (29 - FIRST_HELD) * BYTE_W;
   localparam int OFS_CHECKSUM = (31 - FIRST_HELD) * BYTE_W;

endpackage

// ----- hdl/imufd_if.sv -----
// ----------------------------------------------------------------------------
// imufd channel interfaces
// Valid/ready channels for received bytes and for decoded frames.
// ----------------------------------------------------------------------------

// received byte channel
interface imufd_req_if;
   import imufd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// decoded frame channel
interface imufd_rsp_if;
   import imufd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic        [ID_W-1:0]    frame_id;
   logic signed [WORD_W-1:0]  gyro_x;
   logic signed [WORD_W-1:0]  gyro_y;
   logic signed [WORD_W-1:0]  gyro_z;
   logic signed [WORD_W-1:0]  accel_x;
   logic signed [WORD_W-1:0]  accel_y;
   logic signed [WORD_W-1:0]  accel_z;
   logic signed [TEMP_W-1:0]  temperature_raw;
   logic        [COUNT_W-1:0] frames_counted;
   logic        [COUNT_W-1:0] frames_lost;

   modport source (
      output valid, output frame_id, output gyro_x, output gyro_y, output gyro_z,
      output accel_x, output accel_y, output accel_z, output temperature_raw,
      output frames_counted, output frames_lost, input ready
   );
   modport sink (
      input valid, input frame_id, input gyro_x, input gyro_y, input gyro_z,
      input accel_x, input accel_y, input accel_z, input temperature_raw,
      input frames_counted, input frames_lost, output ready
   );
endinterface

// ----- hdl/imu_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// imu_frame_deframer: 33-byte sensor frame parser
// Finds 55 A4 1C framed packets in a byte stream, checks the sum and trailer
// and returns the little-endian fields with running frame and loss counts.
// ----------------------------------------------------------------------------
//
//   channel      direction  transaction
//   req_stream   in         one received byte (rx_byte)
//   rsp_stream   out        one decoded frame, ids and saturating counts
//
// One byte per clock sustained while no result is stalled. A byte goes
// through an input register and is parsed when the result may advance,
// loading the result register, and so rsp_stream.valid, on a good trailer.
// Reset clears the parser position, sum, id history and counts.
// A stalled result holds the parser; up to one more byte waits in the input
// register, so req_stream.ready drops only while both are full.
//
module imu_frame_deframer (
   input  logic              clock,
   input  logic              reset,
   imufd_req_if.sink         req_stream,
   imufd_rsp_if.source       rsp_stream
);
   import imufd_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // parser state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [HELD_W-1:0] held_ff;
   logic              held_shift;
   logic              have_prev_ff;
   logic [ID_W-1:0]   prev_id_ff;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] lost_ff, lost_in;

   // result register
   logic               rsp_valid_ff;
   logic [HELD_W-BYTE_W-1:0] rsp_data_ff;
   logic [COUNT_W-1:0] rsp_total_ff;
   logic [COUNT_W-1:0] rsp_lost_ff;

   logic advance;
   logic fire;
   logic frame_good;

   // step arithmetic
   logic [ID_W-1:0]    cur_id;
   logic [ID_W-1:0]    id_diff;
   logic [ID_W:0]      id_step;
   logic [ID_W-1:0]    lost_step;
   logic [COUNT_W:0]   total_sum;
   logic [COUNT_W:0]   lost_sum;

   // handshake
   assign advance          = !rsp_valid_ff || rsp_stream.ready;
   assign fire             = in_valid_ff && advance;
   assign req_stream.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_stream.ready) begin
         in_valid_ff <= req_stream.valid;
      end
      if (req_stream.valid && req_stream.ready) begin
         in_byte_ff <= req_stream.rx_byte;
      end
   end

   // id step and saturating counts
   always_comb begin
      cur_id    = held_ff[OFS_ID +: ID_W];
      id_diff   = cur_id - prev_id_ff;
      id_step   = (id_diff == '0) ? {1'b1, {ID_W{1'b0}}} : {1'b0, id_diff};
      lost_step = id_diff - {{(ID_W-1){1'b0}}, 1'b1};
      total_sum = {1'b0, total_ff} + {{(COUNT_W-ID_W){1'b0}}, id_step};
      lost_sum  = {1'b0, lost_ff} + {{(COUNT_W+1-ID_W){1'b0}}, lost_step};
   end

   // parser next state
   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      held_shift = 1'b0;
      frame_good = 1'b0;
      total_in   = total_ff;
      lost_in    = lost_ff;
      if (fire) begin
         if (pos_ff > POS_TRAILER) begin
            pos_in = POS_SYNC0;
         end else if (pos_ff == POS_SYNC0) begin
            if (in_byte_ff == SYNC0_BYTE) begin
               pos_in = POS_SYNC1;
               sum_in = '0;
            end
         end else if (pos_ff == POS_SYNC1) begin
            pos_in = (in_byte_ff == SYNC1_BYTE) ? POS_SYNC2 : POS_SYNC0;
         end else if (pos_ff == POS_SYNC2) begin
            if (in_byte_ff == SYNC2_BYTE) begin
               pos_in = pos_ff + 1'b1;
               sum_in = sum_ff + in_byte_ff;
            end else begin
               pos_in = POS_SYNC0;
            end
         end else if (pos_ff <= POS_SUM_LAST) begin
            pos_in     = pos_ff + 1'b1;
            sum_in     = sum_ff + in_byte_ff;
            held_shift = 1'b1;
         end else if (pos_ff == POS_CHECKSUM) begin
            pos_in     = POS_TRAILER;
            held_shift = 1'b1;
         end else begin
            // trailer byte closes the frame either way
            pos_in     = POS_SYNC0;
            frame_good = (in_byte_ff == TRAILER_BYTE) &&
                         (held_ff[OFS_CHECKSUM +: BYTE_W] == sum_ff);
            if (frame_good && have_prev_ff) begin
               total_in = total_sum[COUNT_W] ? '1 : total_sum[COUNT_W-1:0];
               lost_in  = lost_sum[COUNT_W]  ? '1 : lost_sum[COUNT_W-1:0];
            end
         end
      end
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         have_prev_ff <= 1'b0;
         prev_id_ff   <= '0;
         total_ff     <= '0;
         lost_ff      <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         total_ff <= total_in;
         lost_ff  <= lost_in;
         if (frame_good) begin
            have_prev_ff <= 1'b1;
            prev_id_ff   <= cur_id;
         end
      end
      if (held_shift) begin
         held_ff <= {in_byte_ff, held_ff[HELD_W-1:BYTE_W]};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= frame_good;
      end
      if (frame_good) begin
         rsp_data_ff  <= held_ff[HELD_W-BYTE_W-1:0];
         rsp_total_ff <= total_in;
         rsp_lost_ff  <= lost_in;
      end
   end

   // result fields
   assign rsp_stream.valid           = rsp_valid_ff;
   assign rsp_stream.frame_id        = rsp_data_ff[OFS_ID +: ID_W];
   assign rsp_stream.gyro_x          = $signed(rsp_data_ff[OFS_GYRO_X +: WORD_W]);
   assign rsp_stream.gyro_y          = $signed(rsp_data_ff[OFS_GYRO_Y +: WORD_W]);
   assign rsp_stream.gyro_z          = $signed(rsp_data_ff[OFS_GYRO_Z +: WORD_W]);
   assign rsp_stream.accel_x         = $signed(rsp_data_ff[OFS_ACCEL_X +: WORD_W]);
   assign rsp_stream.accel_y         = $signed(rsp_data_ff[OFS_ACCEL_Y +: WORD_W]);
   assign rsp_stream.accel_z         = $signed(rsp_data_ff[OFS_ACCEL_Z +: WORD_W]);
   assign rsp_stream.temperature_raw = $signed(rsp_data_ff[OFS_TEMP +: TEMP_W]);
   assign rsp_stream.frames_counted  = rsp_total_ff;
   assign rsp_stream.frames_lost     = rsp_lost_ff;

`ifndef SYNTHESIS
   // no result right after reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   // parser position stays inside a frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_TRAILER)
      else $error("parser position out of range");

   // a good trailer always presents a result next cycle
   a_good_frame_out: assert property (@(posedge clock) disable iff (reset)
      frame_good |=> rsp_valid_ff)
      else $error("good frame not presented");

   // losses never exceed the frame count
   a_lost_le_total: assert property (@(posedge clock) disable iff (reset)
      lost_ff <= total_ff)
      else $error("loss count above frame count");
`endif

endmodule

// ----- sim/imufd_frame_checker.sv -----
// ----------------------------------------------------------------------------
// imufd_frame_checker: scoreboard for the imu frame deframer
// Watches the byte and frame channels, predicts each decoded frame from the
// accepted bytes and compares every returned frame field by field.
// ----------------------------------------------------------------------------
module imufd_frame_checker (
   input  logic  clock,
   input  logic  reset,
   imufd_req_if  req_mon,
   imufd_rsp_if  rsp_mon,
   output int    fail_count,
   output int    frames_pending,
   output int    frames_checked
);
   import imufd_pkg::*;

   localparam int          SHOWN_FAILS = 10;
   localparam logic [32:0] ID_SPAN     = 33'd1 << ID_W;

   // byte positions of the fields inside a frame
   localparam int AT_ID      = FIRST_HELD + OFS_ID / BYTE_W;
   localparam int AT_GYRO_X  = FIRST_HELD + OFS_GYRO_X / BYTE_W;
   localparam int AT_GYRO_Y  = FIRST_HELD + OFS_GYRO_Y / BYTE_W;
   localparam int AT_GYRO_Z  = FIRST_HELD + OFS_GYRO_Z / BYTE_W;
   localparam int AT_ACCEL_X = FIRST_HELD + OFS_ACCEL_X / BYTE_W;
   localparam int AT_ACCEL_Y = FIRST_HELD + OFS_ACCEL_Y / BYTE_W;
   localparam int AT_ACCEL_Z = FIRST_HELD + OFS_ACCEL_Z / BYTE_W;
   localparam int AT_TEMP    = FIRST_HELD + OFS_TEMP / BYTE_W;

   typedef struct {
      logic        [ID_W-1:0]    frame_id;
      logic signed [WORD_W-1:0]  gyro_x;
      logic signed [WORD_W-1:0]  gyro_y;
      logic signed [WORD_W-1:0]  gyro_z;
      logic signed [WORD_W-1:0]  accel_x;
      logic signed [WORD_W-1:0]  accel_y;
      logic signed [WORD_W-1:0]  accel_z;
      logic signed [TEMP_W-1:0]  temperature_raw;
      logic        [COUNT_W-1:0] frames_counted;
      logic        [COUNT_W-1:0] frames_lost;
   } frame_fields_type;

   // parser state as the block should hold it
   logic [POS_W-1:0]   position;
   logic [BYTE_W-1:0]  frame_sum;
   logic [BYTE_W-1:0]  held [0:POS_TRAILER];
   logic               seen_frame;
   logic [ID_W-1:0]    last_id;
   logic [COUNT_W-1:0] total_frames;
   logic [COUNT_W-1:0] lost_frames;

   frame_fields_type expected_frames [$];

   function automatic logic [COUNT_W-1:0] add_clamped(logic [COUNT_W-1:0] a,
                                                      logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] word_le(int at);
      return {held[at+3], held[at+2], held[at+1], held[at]};
   endfunction

   function automatic logic [15:0] half_le(int at);
      return {held[at+1], held[at]};
   endfunction

   task automatic flag_failure(input string what);
      fail_count = fail_count + 1;
      if (fail_count <= SHOWN_FAILS)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want)
         flag_failure($sformatf("%s expected %h actual %h", name, want, got));
   endtask

   // advance the parser by one accepted byte, queue a frame on a good trailer
   task automatic predict_byte(input logic [BYTE_W-1:0] b);
      frame_fields_type   fr;
      logic [ID_W-1:0]    id;
      logic [ID_W-1:0]    delta;
      logic [COUNT_W-1:0] stride;
      if (position > POS_TRAILER) begin
         position = POS_SYNC0;
      end else if ((position == POS_SYNC0 && b != SYNC0_BYTE) ||
                   (position == POS_SYNC1 && b != SYNC1_BYTE) ||
                   (position == POS_SYNC2 && b != SYNC2_BYTE)) begin
         position = POS_SYNC0;
      end else if (position != POS_TRAILER) begin
         held[position] = b;
         if (position == POS_SYNC0)
            frame_sum = '0;
         if (position >= POS_SYNC2 && position <= POS_SUM_LAST)
            frame_sum = frame_sum + b;
         position = position + 1'b1;
      end else begin
         position = POS_SYNC0;
         if (b == TRAILER_BYTE && held[POS_CHECKSUM] == frame_sum) begin
            id = half_le(AT_ID);
            // id step, a repeated id stands for a full wrap
            if (seen_frame) begin
               delta  = id - last_id;
               stride = (delta == '0) ? ID_SPAN[COUNT_W-1:0] : COUNT_W'(delta);
               total_frames = add_clamped(total_frames, stride);
               lost_frames  = add_clamped(lost_frames, stride - 1);
            end
            seen_frame = 1'b1;
            last_id    = id;
            fr.frame_id        = id;
            fr.gyro_x          = word_le(AT_GYRO_X);
            fr.gyro_y          = word_le(AT_GYRO_Y);
            fr.gyro_z          = word_le(AT_GYRO_Z);
            fr.accel_x         = word_le(AT_ACCEL_X);
            fr.accel_y         = word_le(AT_ACCEL_Y);
            fr.accel_z         = word_le(AT_ACCEL_Z);
            fr.temperature_raw = half_le(AT_TEMP);
            fr.frames_counted  = total_frames;
            fr.frames_lost     = lost_frames;
            expected_frames.insert(expected_frames.size(), fr);
         end
      end
   endtask

   // result side first, then the byte side of the same edge
   always @(posedge clock) begin
      frame_fields_type want;
      if (reset) begin
         position     = POS_SYNC0;
         frame_sum    = '0;
         seen_frame   = 1'b0;
         last_id      = '0;
         total_frames = '0;
         lost_frames  = '0;
         expected_frames.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_frames.size() == 0) begin
               flag_failure($sformatf("unexpected frame with id %h", rsp_mon.frame_id));
            end else begin
               want = expected_frames.pop_front();
               frames_checked = frames_checked + 1;
               check_field("frame_id", 32'(want.frame_id), 32'(rsp_mon.frame_id));
               check_field("gyro_x", want.gyro_x, rsp_mon.gyro_x);
               check_field("gyro_y", want.gyro_y, rsp_mon.gyro_y);
               check_field("gyro_z", want.gyro_z, rsp_mon.gyro_z);
               check_field("accel_x", want.accel_x, rsp_mon.accel_x);
               check_field("accel_y", want.accel_y, rsp_mon.accel_y);
               check_field("accel_z", want.accel_z, rsp_mon.accel_z);
               check_field("temperature_raw", 32'(want.temperature_raw),
                           32'(rsp_mon.temperature_raw));
               check_field("frames_counted", want.frames_counted, rsp_mon.frames_counted);
               check_field("frames_lost", want.frames_lost, rsp_mon.frames_lost);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_byte(req_mon.rx_byte);
      end
      frames_pending = expected_frames.size();
   end

endmodule

// ----- sim/tb_imu_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_imu_frame_deframer: testbench for the imu frame deframer
// Feeds well-formed, damaged and cut frames mixed with line noise under
// changing stall patterns; the frame checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_imu_frame_deframer;
   import imufd_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASE_BYTES    = 450;
   localparam int TIMEOUT_CYCLES = 400000;

   typedef enum int {
      FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TRAILER, FRAME_BAD_SYNC, FRAME_CUT
   } frame_kind_type;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREME} fill_type;

   logic clock = 1'b0;
   logic reset;

   imufd_req_if req_bus ();
   imufd_rsp_if rsp_bus ();

   int fail_count;
   int frames_pending;
   int frames_checked;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int bytes_sent    = 0;
   int framed_bytes  = 0;

   logic [ID_W-1:0]   next_id = '0;
   logic [BYTE_W-1:0] frame_buf [0:POS_TRAILER];

   imu_frame_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_bus),
      .rsp_stream (rsp_bus)
   );

   imufd_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .frames_pending (frames_pending),
      .frames_checked (frames_checked)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // one byte transaction, with random gaps in front of it
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      bytes_sent = bytes_sent + 1;
   endtask

   // stop offering bytes until every predicted frame came back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (frames_pending != 0);
      @(posedge clock);
   endtask

   // mostly consecutive ids, with skips, repeats and jumps
   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         next_id = next_id + 1'b1;
      else if (r < 82)
         next_id = next_id + ID_W'($urandom_range(2, 400));
      else if (r >= 88)
         next_id = ID_W'($urandom);
      return next_id;
   endfunction

   function automatic fill_type pick_fill();
      int r;
      r = $urandom_range(99);
      if (r < 85) return FILL_RANDOM;
      if (r < 90) return FILL_ZERO;
      if (r < 95) return FILL_ONES;
      return FILL_EXTREME;
   endfunction

   // sync, id, payload, checksum over bytes 2..30, trailer
   task automatic build_frame(input logic [ID_W-1:0] id, input fill_type fill);
      logic [BYTE_W-1:0] sum;
      logic              flip;
      int                lane;
      int                grp;
      flip = $urandom_range(1);
      frame_buf[POS_SYNC0] = SYNC0_BYTE;
      frame_buf[POS_SYNC1] = SYNC1_BYTE;
      frame_buf[POS_SYNC2] = SYNC2_BYTE;
      frame_buf[3] = id[7:0];
      frame_buf[4] = id[15:8];
      for (int p = 5; p <= POS_SUM_LAST; p++) begin
         lane = (p - 5) % 4;
         grp  = (p - 5) / 4;
         case (fill)
            FILL_ZERO: frame_buf[p] = 8'h00;
            FILL_ONES: frame_buf[p] = 8'hFF;
            FILL_EXTREME: begin
               // alternating most negative and most positive values
               if (((grp % 2) == 1) ^ flip)
                  frame_buf[p] = (lane == 3 || p == POS_SUM_LAST) ? 8'h7F : 8'hFF;
               else
                  frame_buf[p] = (lane == 3 || p == POS_SUM_LAST) ? 8'h80 : 8'h00;
            end
            default: frame_buf[p] = BYTE_W'($urandom);
         endcase
      end
      sum = '0;
      for (int p = POS_SYNC2; p <= POS_SUM_LAST; p++)
         sum = sum + frame_buf[p];
      frame_buf[POS_CHECKSUM] = sum;
      frame_buf[POS_TRAILER]  = TRAILER_BYTE;
   endtask

   // bad_at picks the damaged sync byte, only used for a bad header
   task automatic send_frame(input frame_kind_type kind, input logic [ID_W-1:0] id,
                             input fill_type fill, input int bad_at);
      int count;
      build_frame(id, fill);
      count = POS_TRAILER + 1;
      case (kind)
         FRAME_BAD_SUM:
            frame_buf[POS_CHECKSUM] = frame_buf[POS_CHECKSUM] ^ BYTE_W'($urandom_range(1, 255));
         FRAME_BAD_TRAILER:
            frame_buf[POS_TRAILER] = BYTE_W'($urandom_range(1, 255));
         FRAME_BAD_SYNC: begin
            frame_buf[bad_at] = frame_buf[bad_at] ^ BYTE_W'($urandom_range(1, 255));
            count = bad_at + 1;
         end
         FRAME_CUT:
            count = $urandom_range(POS_SYNC2 + 1, POS_TRAILER);
         default: ;
      endcase
      for (int i = 0; i < count; i++)
         send_byte(frame_buf[i]);
      framed_bytes = framed_bytes + count;
   endtask

   // random mix: mostly good frames, some damaged ones and line noise
   task automatic run_random(input int budget);
      int stop_at;
      int r;
      stop_at = framed_bytes + budget;
      while (framed_bytes < stop_at) begin
         r = $urandom_range(99);
         if (r < 72)
            send_frame(FRAME_GOOD, pick_id(), pick_fill(), 0);
         else if (r < 78)
            send_frame(FRAME_BAD_SUM, pick_id(), pick_fill(), 0);
         else if (r < 84)
            send_frame(FRAME_BAD_TRAILER, pick_id(), pick_fill(), 0);
         else if (r < 89)
            send_frame(FRAME_BAD_SYNC, pick_id(), pick_fill(), $urandom_range(0, 2));
         else if (r < 93)
            send_frame(FRAME_CUT, pick_id(), pick_fill(), 0);
         else
            repeat ($urandom_range(1, 20))
               send_byte(($urandom_range(3) == 0) ? SYNC0_BYTE : BYTE_W'($urandom));
      end
   endtask

   // result side: random stalls plus long hold-offs on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = holds_done + 1;
            repeat (HOLD_CYCLES) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // stimulus and verdict
   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // first frame leaves counts alone, repeated id, wrap, extremes
      send_frame(FRAME_GOOD, 16'h0000, FILL_ZERO, 0);
      send_frame(FRAME_GOOD, 16'h0000, FILL_ONES, 0);
      send_frame(FRAME_GOOD, 16'hFFFF, FILL_EXTREME, 0);
      send_frame(FRAME_GOOD, 16'h0000, FILL_EXTREME, 0);
      // damaged checksum and trailer, broken header at each sync byte
      send_frame(FRAME_BAD_SUM, 16'h0001, FILL_RANDOM, 0);
      send_frame(FRAME_BAD_TRAILER, 16'h0002, FILL_RANDOM, 0);
      send_frame(FRAME_BAD_SYNC, 16'h0003, FILL_RANDOM, 0);
      send_frame(FRAME_BAD_SYNC, 16'h0004, FILL_RANDOM, 1);
      send_frame(FRAME_BAD_SYNC, 16'h0005, FILL_RANDOM, 2);
      send_frame(FRAME_GOOD, 16'h0010, FILL_RANDOM, 0);
      // a doubled sync byte is dropped, not retried as a new start
      send_byte(SYNC0_BYTE);
      send_frame(FRAME_GOOD, 16'h0011, FILL_RANDOM, 0);
      send_frame(FRAME_GOOD, 16'h0012, FILL_RANDOM, 0);
      // a cut frame swallows part of the next one
      send_frame(FRAME_CUT, 16'h0013, FILL_RANDOM, 0);
      send_frame(FRAME_GOOD, 16'h0014, FILL_RANDOM, 0);
      send_frame(FRAME_GOOD, 16'h0015, FILL_RANDOM, 0);
      next_id = 16'h0015;
      wait_drained();

      send_idle_pct = 35;
      recv_idle_pct = 59;
      run_random(PHASE_BYTES);

      // long receiver hold-off while frames keep coming, then a full drain
      send_idle_pct = 0;
      hold_requests = hold_requests + 1;
      repeat (4) send_frame(FRAME_GOOD, pick_id(), pick_fill(), 0);
      wait_drained();

      send_idle_pct = 59;
      recv_idle_pct = 35;
      run_random(PHASE_BYTES);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_BYTES);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes, %0d of them in framed sequences, and %0d decoded frames",
               bytes_sent, framed_bytes, frames_checked);
      $display("under three stall mixes and one long result hold-off, %0d mismatches",
               fail_count);
      if (fail_count == 0 && frames_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("timeout with %0d frames still expected", frames_pending);
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- imu_frame_deframer.f -----
hdl/imufd_pkg.sv
hdl/imufd_if.sv
hdl/imu_frame_deframer.sv
sim/imufd_frame_checker.sv
sim/tb_imu_frame_deframer.sv
